### src/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### src/gcd_pkg.sv
// Widths, constants and table functions for the great-circle distance pipeline
`default_nettype none
package gcd_pkg;
  localparam int ANGLE_FRAC_BITS = 20;
  localparam int CORDIC_STEPS_DEF = 24;
  localparam int LAT_W = 28;
  localparam int LON_W = 29;
  localparam int DIST_W = 25;
  localparam int AW = 30;
  localparam int MDW = 27;
  localparam int PW = 54;
  localparam int XW = 34;
  localparam int ZW = 35;
  localparam int MW = 32;
  localparam int PRW = 64;
  localparam int SQW = 61;
  localparam int SQ_STEPS = (SQW + 1) / 2;
  localparam int CAW = 31;
  localparam int ANG_W = 34;
  localparam int ANG_LO_W = 17;
  localparam int KM_W = 29;
  localparam int KPW = ANG_LO_W + KM_W;

  localparam logic signed [AW-1:0] DEG_HALF = AW'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [AW-1:0] DEG_PERIOD = AW'(360 << ANGLE_FRAC_BITS);
  localparam logic [AW-1:0] DEG_QUARTER = AW'(90 << ANGLE_FRAC_BITS);
  localparam logic [MDW-1:0] DEG_TO_RAD = MDW'(74961321);
  localparam logic signed [XW-1:0] GAIN_Q30 = XW'(34'h026DD3B6A);
  localparam logic signed [ZW-1:0] PI_Q32 = ZW'(35'h3243F6A89);
  localparam logic [ZW-1:0] QUARTER_PI_Q32 = ZW'(35'h0C90FDAA2);
  localparam logic signed [MW-1:0] ONE_Q30 = MW'(32'h40000000);
  localparam logic [KM_W-1:0] KM_PER_RAD_Q16 = KM_W'(417509768);

  typedef logic signed [XW-1:0] cxy_t;
  typedef logic signed [ZW-1:0] cz_t;

  // restoring shift-subtract division, elaboration use only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in Q32 from the alternating series in Q62
  function automatic logic [ZW-1:0] atan_q32(input int i);
    logic [63:0] acc;
    logic [63:0] term;
    int sh;
    acc = '0;
    if (i == 0) return QUARTER_PI_Q32;
    for (int k = 0; k < 32; k++) begin
      sh = i * (2 * k + 1);
      if (sh <= 62) begin
        term = udiv64((64'd1 << 62) >> sh, 64'(2 * k + 1));
        if (k % 2 == 1) acc = acc - term;
        else acc = acc + term;
      end
    end
    return ZW'((acc + (64'd1 << 29)) >> 30);
  endfunction
endpackage
`default_nettype wire

### src/gcd_if.sv
// Valid/ready channel interfaces for coordinate pairs and distances
`default_nettype none
interface gcd_in_if;
  import gcd_pkg::*;
  logic valid;
  logic ready;
  logic signed [LAT_W-1:0] lat_a;
  logic signed [LON_W-1:0] lon_a;
  logic signed [LAT_W-1:0] lat_b;
  logic signed [LON_W-1:0] lon_b;
  modport source (output valid, lat_a, lon_a, lat_b, lon_b, input ready);
  modport sink (input valid, lat_a, lon_a, lat_b, lon_b, output ready);
endinterface

interface gcd_out_if;
  import gcd_pkg::*;
  logic valid;
  logic ready;
  logic [DIST_W-1:0] distance_km;
  modport source (output valid, distance_km, input ready);
  modport sink (input valid, distance_km, output ready);
endinterface
`default_nettype wire

### src/gcd_cordic_cell.sv
// One registered CORDIC micro-rotation, rotation or vectoring mode
`default_nettype none
module gcd_cordic_cell import gcd_pkg::*; #(
  parameter int STEP = 0,
  parameter bit VECTORING = 1'b0
) (
  input  wire logic clk_i,
  input  wire logic en_i,
  input  wire cxy_t x_i,
  input  wire cxy_t y_i,
  input  wire cz_t  z_i,
  output cxy_t      x_o,
  output cxy_t      y_o,
  output cz_t       z_o
);
  localparam cz_t ATAN = cz_t'(atan_q32(STEP));

  cxy_t x_q, y_q, dx, dy;
  cz_t  z_q;
  logic up;

  assign dx = y_i >>> STEP;
  assign dy = x_i >>> STEP;
  assign up = VECTORING ? y_i[XW-1] : !z_i[ZW-1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (up) begin
        x_q <= x_i - dx;
        y_q <= y_i + dy;
        z_q <= z_i - ATAN;
      end else begin
        x_q <= x_i + dx;
        y_q <= y_i - dy;
        z_q <= z_i + ATAN;
      end
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
endmodule
`default_nettype wire

### src/gcd_sqrt_cell.sv
// One registered digit of the integer square root
`default_nettype none
module gcd_sqrt_cell import gcd_pkg::*; #(
  parameter int BIT = SQW - 1
) (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire logic [SQW-1:0] rem_i,
  input  wire logic [SQW-1:0] root_i,
  output logic [SQW-1:0]      rem_o,
  output logic [SQW-1:0]      root_o
);
  localparam logic [SQW-1:0] ONE_BIT = SQW'(1) << BIT;

  logic [SQW-1:0] trial, rem_q, root_q;

  assign trial = root_i + ONE_BIT;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (rem_i >= trial) begin
        rem_q  <= rem_i - trial;
        root_q <= (root_i >> 1) + ONE_BIT;
      end else begin
        rem_q  <= rem_i;
        root_q <= root_i >> 1;
      end
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;
endmodule
`default_nettype wire

### src/great_circle_distance.sv
// Top level: great-circle distance pipeline of CORDIC and square-root cells
//
//  channel  dir  payload                         transaction
//  in_i     in   lat_a, lon_a, lat_b, lon_b      valid & ready
//  out_o    out  distance_km                     valid & ready
//
// One transaction per cycle while the output is not stalled; the pipeline holds
// two CORDIC chains of CORDIC_STEPS cells (rotation, then vectoring) with a 31-cell square-root chain between them.
// Reset clears only the stage valid bits; data registers are not reset.
// A result held at the output with ready low freezes the whole pipeline.
`default_nettype none
`include "assert_macros.svh"
module great_circle_distance import gcd_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  gcd_in_if.sink    in_i,
  gcd_out_if.source out_o
);
  localparam int N = CORDIC_STEPS;
  localparam int LAT = 2 * N + 42;

  logic en, acc;
  logic [LAT-1:0] vld_q, eq_q;

  assign en  = !vld_q[LAT-1] || out_o.ready;
  assign acc = in_i.valid && en;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], acc};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      eq_q <= {eq_q[LAT-2:0], (in_i.lat_a == in_i.lat_b) && (in_i.lon_a == in_i.lon_b)};
    end
  end

  // angle reduction into [-180,180)
  logic signed [AW-1:0] ang_in [3];
  logic signed [AW-1:0] red_d [3];
  logic signed [AW-1:0] red_q [3];

  assign ang_in[0] = AW'(in_i.lat_a);
  assign ang_in[1] = AW'(in_i.lat_b);
  assign ang_in[2] = AW'(in_i.lon_a) - AW'(in_i.lon_b);

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (ang_in[l] >= DEG_HALF) red_d[l] = ang_in[l] - DEG_PERIOD;
      else if (ang_in[l] < -DEG_HALF) red_d[l] = ang_in[l] + DEG_PERIOD;
      else red_d[l] = ang_in[l];
    end
  end

  // fold into the first quadrant
  logic [AW-1:0]  mag [3];
  logic [MDW-1:0] m_d [3];
  logic [MDW-1:0] m_q [3];
  logic [2:0]     cn_d;
  logic [2:0]     rneg_q  [N+2];
  logic [2:0]     rcneg_q [N+2];
  logic [PW-1:0]  prod_q [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      mag[l] = red_q[l][AW-1] ? AW'(-red_q[l]) : AW'(red_q[l]);
      if (mag[l] > DEG_QUARTER) begin
        m_d[l]  = MDW'(AW'(DEG_HALF) - mag[l]);
        cn_d[l] = 1'b1;
      end else begin
        m_d[l]  = MDW'(mag[l]);
        cn_d[l] = 1'b0;
      end
    end
  end

  // rotation chains, lane 0 lat_a, lane 1 lat_b, lane 2 longitude difference
  cxy_t rx [3][N+1];
  cxy_t ry [3][N+1];
  cz_t  rz [3][N+1];
  logic [PW-1:0] zr [3];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    assign zr[l] = prod_q[l] + (PW'(1) << (ANGLE_FRAC_BITS - 1));
    assign rx[l][0] = GAIN_Q30;
    assign ry[l][0] = '0;
    assign rz[l][0] = cz_t'(ZW'(zr[l] >> ANGLE_FRAC_BITS));
    for (genvar i = 0; i < N; i++) begin : g_rot
      gcd_cordic_cell #(.STEP(i), .VECTORING(1'b0)) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .x_i   (rx[l][i]),
        .y_i   (ry[l][i]),
        .z_i   (rz[l][i]),
        .x_o   (rx[l][i+1]),
        .y_o   (ry[l][i+1]),
        .z_o   (rz[l][i+1])
      );
    end
  end

  // products and cosine sum
  logic signed [MW-1:0]  sq_q [3];
  logic signed [MW-1:0]  cq_q [3];
  logic signed [PRW-1:0] pcc_q, sab_q, sab2_q, pct_q;
  logic signed [MW-1:0]  ct1_q, p_d, c_d, c_q;
  logic signed [PRW:0]   sum_w;
  logic signed [PRW-1:0] sum_s;
  logic signed [PRW-1:0] csq_w;
  logic [SQW-1:0]        csq_q;

  assign p_d   = MW'((pcc_q + PRW'(64'sd1 << 29)) >>> 30);
  assign sum_w = (PRW+1)'(sab2_q) + (PRW+1)'(pct_q) + (PRW+1)'(65'sd1 << 29);
  assign sum_s = PRW'(sum_w >>> 30);
  assign csq_w = c_q * c_q;

  always_comb begin
    if (sum_s > PRW'(ONE_Q30)) c_d = ONE_Q30;
    else if (sum_s < -PRW'(ONE_Q30)) c_d = -ONE_Q30;
    else c_d = MW'(sum_s);
  end

  // square root of 1 - c^2, then vectoring chain
  logic [SQW-1:0] srem  [SQ_STEPS+1];
  logic [SQW-1:0] sroot [SQ_STEPS+1];
  logic [CAW-1:0] vabs_q [SQ_STEPS+1];
  logic           vneg_q [SQ_STEPS+N+1];
  cxy_t vx [N+1];
  cxy_t vy [N+1];
  cz_t  vz [N+1];

  assign srem[0]  = (SQW'(1) << (SQW - 1)) - csq_q;
  assign sroot[0] = '0;

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    gcd_sqrt_cell #(.BIT(SQW - 1 - 2 * j)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (srem[j]),
      .root_i (sroot[j]),
      .rem_o  (srem[j+1]),
      .root_o (sroot[j+1])
    );
  end

  assign vx[0] = cxy_t'(XW'(vabs_q[SQ_STEPS]));
  assign vy[0] = cxy_t'(XW'(sroot[SQ_STEPS]));
  assign vz[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_vec
    gcd_cordic_cell #(.STEP(i), .VECTORING(1'b1)) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .x_i   (vx[i]),
      .y_i   (vy[i]),
      .z_i   (vz[i]),
      .x_o   (vx[i+1]),
      .y_o   (vy[i+1]),
      .z_o   (vz[i+1])
    );
  end

  // angle to distance
  cz_t                z_adj;
  logic [ANG_W-1:0]   ang_d, ang_q;
  logic [KPW-1:0]     hi_q, lo_q;
  logic [63:0]        tot;
  logic [DIST_W-1:0]  dist_q;

  always_comb begin
    z_adj = vneg_q[SQ_STEPS+N] ? PI_Q32 - vz[N] : vz[N];
    if (z_adj[ZW-1]) ang_d = '0;
    else if (z_adj > PI_Q32) ang_d = ANG_W'(PI_Q32);
    else ang_d = ANG_W'(z_adj);
  end

  assign tot = (64'(hi_q) << ANG_LO_W) + 64'(lo_q) + (64'd1 << 37);

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        red_q[l]  <= red_d[l];
        m_q[l]    <= m_d[l];
        prod_q[l] <= PW'(m_q[l]) * PW'(DEG_TO_RAD);
        sq_q[l]   <= rneg_q[N+1][l] ? MW'(-ry[l][N]) : MW'(ry[l][N]);
        cq_q[l]   <= rcneg_q[N+1][l] ? MW'(-rx[l][N]) : MW'(rx[l][N]);
      end
      rneg_q[0]  <= {red_q[2][AW-1], red_q[1][AW-1], red_q[0][AW-1]};
      rcneg_q[0] <= cn_d;
      for (int k = 1; k < N + 2; k++) begin
        rneg_q[k]  <= rneg_q[k-1];
        rcneg_q[k] <= rcneg_q[k-1];
      end
      pcc_q  <= cq_q[0] * cq_q[1];
      sab_q  <= sq_q[0] * sq_q[1];
      ct1_q  <= cq_q[2];
      pct_q  <= p_d * ct1_q;
      sab2_q <= sab_q;
      c_q    <= c_d;
      csq_q  <= SQW'(csq_w);
      vabs_q[0] <= c_q[MW-1] ? CAW'(-c_q) : CAW'(c_q);
      vneg_q[0] <= c_q[MW-1];
      for (int k = 1; k < SQ_STEPS + 1; k++) vabs_q[k] <= vabs_q[k-1];
      for (int k = 1; k < SQ_STEPS + N + 1; k++) vneg_q[k] <= vneg_q[k-1];
      ang_q  <= ang_d;
      hi_q   <= KPW'(ang_q[ANG_W-1:ANG_LO_W]) * KPW'(KM_PER_RAD_Q16);
      lo_q   <= KPW'(ang_q[ANG_LO_W-1:0]) * KPW'(KM_PER_RAD_Q16);
      dist_q <= eq_q[LAT-2] ? '0 : DIST_W'(tot >> 38);
    end
  end

  assign out_o.valid       = vld_q[LAT-1];
  assign out_o.distance_km = dist_q;

  `ASSERT_IMPLIES(a_equal_points_zero, clk_i, rst_ni, out_o.valid && eq_q[LAT-1], out_o.distance_km == '0)
  `ASSERT_IMPLIES(a_stall_blocks_input, clk_i, rst_ni, out_o.valid && !out_o.ready, !in_i.ready)
  `ASSERT_NEXT(a_accept_enters, clk_i, rst_ni, in_i.valid && in_i.ready, vld_q[0])
endmodule
`default_nettype wire
